// ===== sv/lspf_pkg.sv =====
// shared constants, types and helpers for the light sweep peak finder
package lspf_pkg;

    localparam int SAMPLE_PORT_BITS  = 16;
    localparam int STEP_BITS         = 8;
    localparam int TOTAL_BITS        = 26;
    localparam int ANGLE_BITS        = 15;
    localparam int PERCENT_BITS      = 16;
    localparam int SCALE_BITS        = 7;
    localparam int CFG_INDEX_BITS    = 1;

    localparam int DEF_SAMPLE_BITS   = 16;
    localparam int DEF_MAX_STEPS     = 180;

    localparam logic [SCALE_BITS-1:0]   PERCENT_SCALE   = 7'd100;
    localparam logic [ANGLE_BITS-1:0]   ANGLE_MAX       = 15'd32767;
    localparam logic [PERCENT_BITS-1:0] PERCENT_MAX     = 16'd65535;
    localparam logic [STEP_BITS-1:0]    STEPS_RESET     = 8'd30;
    localparam logic [STEP_BITS-1:0]    DEGREES_RESET   = 8'd6;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SWEEP_STEPS      = 1'b0,
        REG_DEGREES_PER_STEP = 1'b1
    } lspf_reg_index_t;

    // degrees times position, clipped to the angle port range
    function automatic logic [ANGLE_BITS-1:0] sat_angle(
        input logic [2*STEP_BITS-1:0] prod
    );
        logic [ANGLE_BITS-1:0] res;
        if (prod > (2*STEP_BITS)'(ANGLE_MAX)) begin
            res = ANGLE_MAX;
        end else begin
            res = prod[ANGLE_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/light_sweep_peak_finder_core.sv =====
// top level of the light sweep peak finder
// Each transfer on the s_ channel carries four photosensor samples for one sweep
// position and yields exactly one transfer on the m_ channel. A mid-sweep step
// passes through the accept, accumulate and result load states, waiting in the
// last until the output register is free, and returns the next servo angle. The
// step that completes the sweep also reports the best position, its angle and
// 100*total/(steps*min); that step runs the restoring divider one quotient bit
// per cycle over the 33-bit dividend, or skips it when the minimum is zero.
// Input is taken again as soon as the result sits in the output register, even
// while it waits on m_ready.
module light_sweep_peak_finder_core #(
    parameter int SAMPLE_BITS = lspf_pkg::DEF_SAMPLE_BITS,
    parameter int MAX_STEPS   = lspf_pkg::DEF_MAX_STEPS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [lspf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [lspf_pkg::STEP_BITS-1:0]        cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [lspf_pkg::SAMPLE_PORT_BITS-1:0] s_sample_a,
    input  logic [lspf_pkg::SAMPLE_PORT_BITS-1:0] s_sample_b,
    input  logic [lspf_pkg::SAMPLE_PORT_BITS-1:0] s_sample_c,
    input  logic [lspf_pkg::SAMPLE_PORT_BITS-1:0] s_sample_d,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [lspf_pkg::ANGLE_BITS-1:0]       m_servo_angle,
    output logic                                  m_sweep_done,
    output logic [lspf_pkg::STEP_BITS-1:0]        m_best_position,
    output logic [lspf_pkg::PERCENT_BITS-1:0]     m_percent_vs_mean,
    output logic                                  m_zero_minimum
);

    localparam int SUM_BITS      = SAMPLE_BITS + 2;
    localparam int STEP_BITS     = lspf_pkg::STEP_BITS;
    localparam int PROD_BITS     = 2 * STEP_BITS;
    localparam int TOTAL_BITS    = lspf_pkg::TOTAL_BITS;
    localparam int DIVIDEND_BITS = TOTAL_BITS + lspf_pkg::SCALE_BITS;
    localparam int DIVISOR_BITS  = STEP_BITS + SUM_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic [STEP_BITS-1:0] sweep_steps_reg;
    logic [STEP_BITS-1:0] degrees_reg;

    logic [SAMPLE_BITS-1:0] sample_a_reg;
    logic [SAMPLE_BITS-1:0] sample_b_reg;
    logic [SAMPLE_BITS-1:0] sample_c_reg;
    logic [SAMPLE_BITS-1:0] sample_d_reg;

    logic [STEP_BITS-1:0]  position_count_reg;
    logic [SUM_BITS-1:0]   smallest_sum_reg;
    logic [STEP_BITS-1:0]  smallest_position_reg;
    logic [TOTAL_BITS-1:0] running_total_reg;

    logic [lspf_pkg::ANGLE_BITS-1:0]   res_angle_reg;
    logic                              res_done_reg;
    logic [STEP_BITS-1:0]              res_best_reg;
    logic [lspf_pkg::PERCENT_BITS-1:0] res_percent_reg;
    logic                              res_zero_reg;

    logic [DIVIDEND_BITS-1:0] dividend_reg;
    logic [DIVISOR_BITS-1:0]  divisor_reg;
    logic                     div_start_reg;

    logic                              m_valid_reg;
    logic [lspf_pkg::ANGLE_BITS-1:0]   m_angle_reg;
    logic                              m_done_reg;
    logic [STEP_BITS-1:0]              m_best_reg;
    logic [lspf_pkg::PERCENT_BITS-1:0] m_percent_reg;
    logic                              m_zero_reg;

    logic [SUM_BITS-1:0]      step_sum;
    logic [STEP_BITS-1:0]     count_next;
    logic [STEP_BITS-1:0]     steps_eff;
    logic                     div_done;
    logic [DIVIDEND_BITS-1:0] div_quotient;

    always_comb begin
        step_sum   = SUM_BITS'(sample_a_reg) + SUM_BITS'(sample_b_reg)
                   + SUM_BITS'(sample_c_reg) + SUM_BITS'(sample_d_reg);
        count_next = position_count_reg + 1'b1;
        if (sweep_steps_reg == '0) begin
            steps_eff = STEP_BITS'(1);
        end else if (sweep_steps_reg > STEP_BITS'(MAX_STEPS)) begin
            steps_eff = STEP_BITS'(MAX_STEPS);
        end else begin
            steps_eff = sweep_steps_reg;
        end
    end

    lspf_divider #(
        .NUM_BITS (DIVIDEND_BITS),
        .DEN_BITS (DIVISOR_BITS)
    ) u_divider (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (div_start_reg),
        .numerator   (dividend_reg),
        .denominator (divisor_reg),
        .done        (div_done),
        .quotient    (div_quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_steps_reg <= lspf_pkg::STEPS_RESET;
            degrees_reg     <= lspf_pkg::DEGREES_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lspf_pkg::REG_SWEEP_STEPS:      sweep_steps_reg <= cfg_wdata;
                lspf_pkg::REG_DEGREES_PER_STEP: degrees_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg             <= ST_IDLE;
            position_count_reg    <= '0;
            smallest_sum_reg      <= '0;
            smallest_position_reg <= '0;
            running_total_reg     <= '0;
            div_start_reg         <= 1'b0;
            m_valid_reg           <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            // the output state reloads or holds the output register itself
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        sample_a_reg <= s_sample_a[SAMPLE_BITS-1:0];
                        sample_b_reg <= s_sample_b[SAMPLE_BITS-1:0];
                        sample_c_reg <= s_sample_c[SAMPLE_BITS-1:0];
                        sample_d_reg <= s_sample_d[SAMPLE_BITS-1:0];
                        state_reg    <= ST_ACCUM;
                    end
                end
                ST_ACCUM: begin
                    if (position_count_reg == '0) begin
                        smallest_sum_reg      <= step_sum;
                        smallest_position_reg <= '0;
                        running_total_reg     <= TOTAL_BITS'(step_sum);
                    end else begin
                        running_total_reg <= running_total_reg + TOTAL_BITS'(step_sum);
                        if (step_sum < smallest_sum_reg) begin
                            smallest_sum_reg      <= step_sum;
                            smallest_position_reg <= position_count_reg;
                        end
                    end
                    position_count_reg <= count_next;
                    if (count_next < steps_eff) begin
                        res_angle_reg   <= lspf_pkg::sat_angle(PROD_BITS'(degrees_reg)
                                                               * PROD_BITS'(count_next));
                        res_done_reg    <= 1'b0;
                        res_best_reg    <= '0;
                        res_percent_reg <= '0;
                        res_zero_reg    <= 1'b0;
                        state_reg       <= ST_OUT;
                    end else begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    res_angle_reg <= lspf_pkg::sat_angle(PROD_BITS'(degrees_reg)
                                                         * PROD_BITS'(smallest_position_reg));
                    res_done_reg  <= 1'b1;
                    res_best_reg  <= smallest_position_reg;
                    dividend_reg  <= DIVIDEND_BITS'(running_total_reg)
                                   * DIVIDEND_BITS'(lspf_pkg::PERCENT_SCALE);
                    divisor_reg   <= DIVISOR_BITS'(steps_eff) * DIVISOR_BITS'(smallest_sum_reg);
                    // new sweep starts from clean state
                    position_count_reg    <= '0;
                    smallest_sum_reg      <= '0;
                    smallest_position_reg <= '0;
                    running_total_reg     <= '0;
                    if (smallest_sum_reg == '0) begin
                        res_percent_reg <= lspf_pkg::PERCENT_MAX;
                        res_zero_reg    <= 1'b1;
                        state_reg       <= ST_OUT;
                    end else begin
                        res_zero_reg  <= 1'b0;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (div_quotient > DIVIDEND_BITS'(lspf_pkg::PERCENT_MAX)) begin
                            res_percent_reg <= lspf_pkg::PERCENT_MAX;
                        end else begin
                            res_percent_reg <= div_quotient[lspf_pkg::PERCENT_BITS-1:0];
                        end
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // wait for the output register to free up
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_angle_reg   <= res_angle_reg;
                        m_done_reg    <= res_done_reg;
                        m_best_reg    <= res_best_reg;
                        m_percent_reg <= res_percent_reg;
                        m_zero_reg    <= res_zero_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_servo_angle     = m_angle_reg;
    assign m_sweep_done      = m_done_reg;
    assign m_best_position   = m_best_reg;
    assign m_percent_vs_mean = m_percent_reg;
    assign m_zero_minimum    = m_zero_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after a transfer");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        position_count_reg <= STEP_BITS'(MAX_STEPS))
        else $error("position count passed the step limit");

    a_zero_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_zero_reg |-> m_done_reg && (m_percent_reg == lspf_pkg::PERCENT_MAX))
        else $error("zero minimum without saturated report");

    a_mid_sweep_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_done_reg |-> (m_best_reg == '0) && (m_percent_reg == '0))
        else $error("report fields set on a mid-sweep result");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");
`endif

endmodule

// ===== sv/lspf_divider.sv =====
// restoring divider, one quotient bit per clock
module lspf_divider #(
    parameter int NUM_BITS = 33,
    parameter int DEN_BITS = 26
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_BITS-1:0] numerator,
    input  logic [DEN_BITS-1:0] denominator,
    output logic                done,
    output logic [NUM_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] num_reg;
    logic [DEN_BITS-1:0] rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic                fits;
    logic [DEN_BITS-1:0] rem_next;
    logic [NUM_BITS-1:0] num_next;

    always_comb begin
        trial    = {rem_reg, num_reg[NUM_BITS-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        // quotient bits shift in where the dividend bits leave
        num_next = {num_reg[NUM_BITS-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                num_reg   <= numerator;
                den_reg   <= denominator;
                rem_reg   <= '0;
                count_reg <= CNT_BITS'(NUM_BITS);
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                num_reg   <= num_next;
                rem_reg   <= rem_next;
                count_reg <= count_reg - 1'b1;
                if (count_reg == CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule
